>>> sv/assert_macros.svh
// Assertion macros shared by the ramp phase generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property on clk_i, off while rst_ni is low.
`define VRPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication on clk_i, off while rst_ni is low.
`define VRPG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/vrpg_pkg.sv
// Shared widths, register codes and stage records of the ramp phase generator.
package vrpg_pkg;

  localparam int FREQ_BITS   = 24;
  localparam int PHASE_BITS  = 32;
  localparam int STEP_BITS   = 24;
  localparam int MGAIN_BITS  = 24;
  localparam int PGAIN_BITS  = 32;
  localparam int INDEX_BITS  = 16;
  localparam int MGAIN_SHIFT = 24;
  localparam int PGAIN_SHIFT = 16;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = 16'd32768;

  localparam int IDX_RAW_BITS = FREQ_BITS + MGAIN_BITS - MGAIN_SHIFT;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam int IN_FIELD_BITS  = FREQ_BITS + 2;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = PHASE_BITS + INDEX_BITS + 3 + FREQ_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_ACCEL_STEP = 2'd0,
    REG_MOD_GAIN   = 2'd1,
    REG_PHASE_GAIN = 2'd2
  } cfg_reg_e;

  // State after one tick: ramped frequency, direction and active flag.
  typedef struct packed {
    logic [FREQ_BITS-1:0] freq;
    logic                 dir;
    logic                 active;
  } ramp_rec_t;

  // Scaled products of one tick, with the state they came from.
  typedef struct packed {
    logic [IDX_RAW_BITS-1:0] idx_raw;
    logic [PHASE_BITS-1:0]   ph_inc;
    ramp_rec_t               rec;
  } prod_rec_t;

  typedef struct packed {
    logic [OUT_TDATA_BITS-OUT_FIELD_BITS-1:0] pad;
    logic [FREQ_BITS-1:0]                     present_freq;
    logic                                     drive_update;
    logic                                     active;
    logic                                     direction;
    logic [INDEX_BITS-1:0]                    mod_index;
    logic [PHASE_BITS-1:0]                    phase;
  } out_word_t;

endpackage

>>> sv/vrpg_ramp.sv
// Ramp stage: enable and direction handshake with the motor and frequency ramp.
`include "assert_macros.svh"

module vrpg_ramp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [vrpg_pkg::STEP_BITS-1:0]   accel_step_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [vrpg_pkg::FREQ_BITS-1:0]   target_freq_i,
  input  logic                             requested_dir_i,
  input  logic                             requested_enable_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output vrpg_pkg::ramp_rec_t              rec_o
);
  import vrpg_pkg::*;

  localparam int CW = ((FREQ_BITS > STEP_BITS) ? FREQ_BITS : STEP_BITS) + 1;

  ramp_rec_t rec_q, rec_d;
  logic      valid_q, valid_d;
  logic      accept;

  logic [CW-1:0] f0, s, t, f1, f2;
  logic          act1, dir2;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign f0 = CW'(rec_q.freq);
  assign s  = CW'(accel_step_i);
  assign t  = CW'(target_freq_i);

  always_comb begin
    f1   = f0;
    act1 = rec_q.active;
    dir2 = rec_q.dir;
    // Enable change: ramp to zero, then take the request.
    if (requested_enable_i != rec_q.active) begin
      if (f0 <= s) begin
        f1   = '0;
        act1 = requested_enable_i;
      end else begin
        f1 = f0 - s;
      end
    end
    f2 = f1;
    if (act1 && (requested_enable_i == act1)) begin
      if (requested_dir_i != rec_q.dir) begin
        // Direction change: ramp to zero, then switch.
        if (f1 <= s) begin
          f2   = '0;
          dir2 = requested_dir_i;
        end else begin
          f2 = f1 - s;
        end
      end else if (f1 > t) begin
        f2 = ((f1 - t) <= s) ? t : (f1 - s);
      end else if (f1 < t) begin
        f2 = ((t - f1) <= s) ? t : (f1 + s);
      end
    end
  end

  always_comb begin
    rec_d = rec_q;
    if (accept) begin
      rec_d.freq   = f2[FREQ_BITS-1:0];
      rec_d.dir    = dir2;
      rec_d.active = act1;
    end
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      rec_q   <= rec_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

  `VRPG_ASSERT_IMPL(a_idle_at_zero, !rec_q.active, rec_q.freq == '0, "inactive with nonzero frequency")
  `VRPG_ASSERT_IMPL(a_dir_flip_at_zero, !$stable(rec_q.dir), rec_q.freq == '0, "direction switched while turning")
  `VRPG_ASSERT_IMPL(a_act_drop_at_zero, $fell(rec_q.active), rec_q.freq == '0, "disabled while turning")

endmodule

>>> sv/vrpg_mult.sv
// Product stage: frequency times modulation gain and phase gain, registered.
module vrpg_mult (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [vrpg_pkg::MGAIN_BITS-1:0]  mod_gain_i,
  input  logic [vrpg_pkg::PGAIN_BITS-1:0]  phase_gain_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  vrpg_pkg::ramp_rec_t              rec_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output vrpg_pkg::prod_rec_t              prod_o
);
  import vrpg_pkg::*;

  logic [FREQ_BITS+MGAIN_BITS-1:0] idx_full;
  logic [FREQ_BITS+PGAIN_BITS-1:0] ph_full;
  prod_rec_t                       prod_q;
  logic                            valid_q;
  logic                            load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  assign idx_full = (FREQ_BITS+MGAIN_BITS)'(rec_i.freq) * (FREQ_BITS+MGAIN_BITS)'(mod_gain_i);
  assign ph_full  = (FREQ_BITS+PGAIN_BITS)'(rec_i.freq) * (FREQ_BITS+PGAIN_BITS)'(phase_gain_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_q.idx_raw <= idx_full[MGAIN_SHIFT +: IDX_RAW_BITS];
      prod_q.ph_inc  <= ph_full[PGAIN_SHIFT +: PHASE_BITS];
      prod_q.rec     <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign prod_o      = prod_q;

endmodule

>>> sv/vrpg_acc.sv
// Output stage: index saturation, phase accumulator and result register.
`include "assert_macros.svh"

module vrpg_acc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  vrpg_pkg::prod_rec_t              prod_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [vrpg_pkg::PHASE_BITS-1:0]  phase_o,
  output logic [vrpg_pkg::INDEX_BITS-1:0]  mod_index_o,
  output logic                             direction_o,
  output logic                             active_o,
  output logic                             drive_update_o,
  output logic [vrpg_pkg::FREQ_BITS-1:0]   present_freq_o
);
  import vrpg_pkg::*;

  localparam int SW = (IDX_RAW_BITS > INDEX_BITS) ? IDX_RAW_BITS : INDEX_BITS;

  logic [SW-1:0]         idx_ext;
  logic [INDEX_BITS-1:0] mod_d, mod_q;
  logic [PHASE_BITS-1:0] phase_d, phase_q;
  logic [FREQ_BITS-1:0]  freq_q;
  logic                  dir_q, act_q;
  logic                  valid_q;
  logic                  load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  assign idx_ext = SW'(prod_i.idx_raw);

  always_comb begin
    if (!prod_i.rec.active) begin
      mod_d = '0;
    end else if (idx_ext > SW'(INDEX_MAX)) begin
      mod_d = INDEX_MAX;
    end else begin
      mod_d = idx_ext[INDEX_BITS-1:0];
    end
    // Advance only while driving; hold otherwise.
    phase_d = prod_i.rec.active ? (phase_q + prod_i.ph_inc) : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= phase_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mod_q  <= mod_d;
      freq_q <= prod_i.rec.freq;
      dir_q  <= prod_i.rec.dir;
      act_q  <= prod_i.rec.active;
    end
  end

  assign out_valid_o    = valid_q;
  assign phase_o        = phase_q;
  assign mod_index_o    = mod_q;
  assign direction_o    = dir_q;
  assign active_o       = act_q;
  assign drive_update_o = act_q;
  assign present_freq_o = freq_q;

  `VRPG_ASSERT_IMPL(a_index_sat, valid_q, mod_q <= INDEX_MAX, "modulation index above one")
  `VRPG_ASSERT_IMPL(a_idle_no_index, valid_q && !act_q, mod_q == '0, "index while inactive")
  `VRPG_ASSERT(a_phase_moves_on_drive, $stable(phase_q) || $past(load && prod_i.rec.active), "phase moved without a driving word")

endmodule

>>> sv/vf_ramp_phase_generator_core.sv
// Top level: stream ports, configuration registers and the three pipeline stages.
// An accepted word passes the ramp, product and output stage registers in turn to m_axis.
// Throughput: one word per cycle; s_axis ready drops only while all three stages
// hold words and m_axis is stalled.
// The ramp state turns over with each accepted word in the ramp stage; the two gain
// products sit in their own stage, the phase accumulator in the output stage.
// Reset (rst_ni low, asynchronous): pipeline empty, forward, inactive, frequency
// and phase zero, accel_step one, both gains zero.
module vf_ramp_phase_generator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vrpg_pkg::CFG_ADDR_BITS-1:0]   cfg_index_i,
  input  logic [vrpg_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // target_freq, requested_dir, requested_enable, zero pad
  input  logic [vrpg_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // phase, mod_index, direction, active, drive_update, present_freq, zero pad
  output logic [vrpg_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);
  import vrpg_pkg::*;

  logic [STEP_BITS-1:0]  accel_step_q;
  logic [MGAIN_BITS-1:0] mod_gain_q;
  logic [PGAIN_BITS-1:0] phase_gain_q;
  logic                  cfg_wr;

  ramp_rec_t rec;
  prod_rec_t prod;
  logic      ramp_valid, mult_ready, mult_valid, acc_ready;
  out_word_t word;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_step_q <= STEP_BITS'(1);
      mod_gain_q   <= '0;
      phase_gain_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ACCEL_STEP: accel_step_q <= cfg_data_i[STEP_BITS-1:0];
        REG_MOD_GAIN:   mod_gain_q   <= cfg_data_i[MGAIN_BITS-1:0];
        REG_PHASE_GAIN: phase_gain_q <= cfg_data_i[PGAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  vrpg_ramp u_ramp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accel_step_i       (accel_step_q),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .target_freq_i      (s_axis_tdata[FREQ_BITS-1:0]),
    .requested_dir_i    (s_axis_tdata[FREQ_BITS]),
    .requested_enable_i (s_axis_tdata[FREQ_BITS+1]),
    .out_valid_o        (ramp_valid),
    .out_ready_i        (mult_ready),
    .rec_o              (rec)
  );

  vrpg_mult u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mod_gain_i   (mod_gain_q),
    .phase_gain_i (phase_gain_q),
    .in_valid_i   (ramp_valid),
    .in_ready_o   (mult_ready),
    .rec_i        (rec),
    .out_valid_o  (mult_valid),
    .out_ready_i  (acc_ready),
    .prod_o       (prod)
  );

  assign word.pad = '0;

  vrpg_acc u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (mult_valid),
    .in_ready_o     (acc_ready),
    .prod_i         (prod),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .phase_o        (word.phase),
    .mod_index_o    (word.mod_index),
    .direction_o    (word.direction),
    .active_o       (word.active),
    .drive_update_o (word.drive_update),
    .present_freq_o (word.present_freq)
  );

  assign m_axis_tdata = word;

endmodule
